// ----- rtl/ratree_pkg.sv -----
// ----------------------------------------------------------------------------
// ratree_pkg
// shared constants, types and command structs of the range assign max tree
// ----------------------------------------------------------------------------
package ratree_pkg;

  localparam int LEAVES = 1024;
  localparam int LEVELS = $clog2(LEAVES);
  localparam int NODES  = 2 * LEAVES;
  localparam int AW     = LEVELS + 1;          // node address width
  localparam int IW     = 10;                  // range field width
  localparam int VW     = 31;                  // value width
  localparam int LVL_W  = $clog2(LEVELS + 1);
  localparam logic [VW-1:0] VMAX = {VW{1'b1}};

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_ASSIGN = 2'd1,
    KIND_PLACE  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef struct packed {
    logic          flag;
    logic [VW-1:0] pend;
    logic [VW-1:0] max;
  } node_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_NODE, RD_LEFT, RD_RIGHT, RD_ROOT, RD_LOOP
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_CLR, WR_LEFT_TAG, WR_RIGHT_TAG, WR_UNTAG, WR_REBUILD, WR_LOOP
  } wr_sel_e;

  typedef enum logic [1:0] {
    HOLD_KEEP, HOLD_TAG, HOLD_LOAD_MAX, HOLD_MAX_MAX
  } hold_sel_e;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_START, ST_PUSH_RD, ST_PUSH_CHK, ST_PUSH_WL, ST_PUSH_WR,
    ST_PUSH_UT, ST_LOOP, ST_LOOP_END, ST_SUM, ST_BLD_L, ST_BLD_R, ST_BLD_N,
    ST_BLD_W, ST_ROOT_RD, ST_ROOT_WT
  } state_e;

  typedef struct packed {
    logic             load;
    logic             loop_init;
    logic             loop_step;
    logic             sum;
    logic             out_en;
    logic             clr_en;
    rd_sel_e          rd_sel;
    wr_sel_e          wr_sel;
    hold_sel_e        hold_sel;
    logic [LVL_W-1:0] level;
    logic             path_hi;
  } ctrl_t;

  typedef struct packed {
    kind_e kind;
    logic  empty;
    logic  flag;
    logic  loop_run;
    logic  clr_last;
    logic  out_busy;
  } stat_t;

endpackage

// ----- rtl/ratree_dp.sv -----
// ----------------------------------------------------------------------------
// ratree_dp
// tree memory, range walk registers, accumulator and output register
// ----------------------------------------------------------------------------
module ratree_dp import ratree_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    kind_i,
  input  logic [IW-1:0] range_low_i,
  input  logic [IW-1:0] range_high_i,
  input  logic [VW-1:0] value_i,
  input  ctrl_t         ctrl_i,
  output stat_t         stat_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic [VW-1:0] range_result_o,
  output logic [VW-1:0] total_max_o,
  output logic          saturated_o
);

  node_t         mem_q [NODES];
  node_t         rdata_q;
  kind_e         kind_q;
  logic [IW-1:0] lo_q, hi_q;
  logic [VW-1:0] val_q, acc_q, hold_q, res_q;
  logic          sat_q, acc_v_q;
  logic [AW:0]   l_q, r_q;
  logic [AW-1:0] clr_cnt_q;
  logic          out_valid_q, out_sat_q;
  logic [VW-1:0] out_res_q, out_tot_q;

  logic [AW-1:0] leaf, k, left, right, visit_node, raddr, waddr;
  logic [AW:0]   r_dec;
  logic          visit, rd_en, we;
  node_t         wdata;
  logic [VW:0]   sum;

  assign leaf       = {1'b1, (ctrl_i.path_hi ? hi_q : lo_q)};
  assign k          = leaf >> ctrl_i.level;
  assign left       = {k[AW-2:0], 1'b0};
  assign right      = {k[AW-2:0], 1'b1};
  assign r_dec      = r_q - 1'b1;
  assign visit      = l_q[0] | r_q[0];
  assign visit_node = l_q[0] ? l_q[AW-1:0] : r_dec[AW-1:0];
  assign sum        = {1'b0, acc_q} + {1'b0, val_q};

  always_comb begin
    rd_en = 1'b1;
    unique case (ctrl_i.rd_sel)
      RD_NODE:  raddr = k;
      RD_LEFT:  raddr = left;
      RD_RIGHT: raddr = right;
      RD_ROOT:  raddr = AW'(1);
      RD_LOOP: begin
        raddr = visit_node;
        rd_en = visit;
      end
      default: begin
        raddr = '0;
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = k;
    wdata = '0;
    unique case (ctrl_i.wr_sel)
      WR_CLR:       waddr = clr_cnt_q;
      WR_LEFT_TAG: begin
        waddr = left;
        wdata = '{flag: 1'b1, pend: hold_q, max: hold_q};
      end
      WR_RIGHT_TAG: begin
        waddr = right;
        wdata = '{flag: 1'b1, pend: hold_q, max: hold_q};
      end
      WR_UNTAG:     wdata = '{flag: 1'b0, pend: '0, max: rdata_q.max};
      WR_REBUILD: begin
        wdata = '{flag: 1'b0, pend: rdata_q.pend, max: hold_q};
        we    = !rdata_q.flag;
      end
      WR_LOOP: begin
        waddr = visit_node;
        wdata = '{flag: 1'b1, pend: res_q, max: res_q};
        we    = visit;
      end
      default:      we = 1'b0;
    endcase
  end

  // tree storage, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      kind_q <= kind_e'(kind_i);
      lo_q   <= range_low_i;
      hi_q   <= range_high_i;
      val_q  <= value_i;
      res_q  <= (kind_e'(kind_i) == KIND_ASSIGN && range_low_i <= range_high_i) ?
                value_i : '0;
      sat_q  <= 1'b0;
    end else if (ctrl_i.sum) begin
      if (kind_q == KIND_QUERY) begin
        res_q <= acc_q;
      end else if (kind_q == KIND_PLACE) begin
        res_q <= sum[VW] ? VMAX : sum[VW-1:0];
        sat_q <= sum[VW];
      end
    end
    if (ctrl_i.loop_init) begin
      l_q   <= {2'b01, lo_q};
      r_q   <= {2'b01, hi_q} + 1'b1;
      acc_q <= '0;
    end else begin
      if (ctrl_i.loop_step) begin
        if (l_q[0]) begin
          l_q <= l_q + 1'b1;
        end else if (r_q[0]) begin
          r_q <= r_dec;
        end else begin
          l_q <= l_q >> 1;
          r_q <= r_q >> 1;
        end
      end
      if (acc_v_q && rdata_q.max > acc_q) begin
        acc_q <= rdata_q.max;
      end
    end
    unique case (ctrl_i.hold_sel)
      HOLD_TAG:      hold_q <= rdata_q.pend;
      HOLD_LOAD_MAX: hold_q <= rdata_q.max;
      HOLD_MAX_MAX:  hold_q <= (rdata_q.max > hold_q) ? rdata_q.max : hold_q;
      default:       hold_q <= hold_q;
    endcase
    if (ctrl_i.out_en) begin
      out_res_q <= res_q;
      out_tot_q <= rdata_q.max;
      out_sat_q <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_v_q     <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_v_q <= (ctrl_i.rd_sel == RD_LOOP) && visit;
      if (ctrl_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (ctrl_i.out_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o = '{kind: kind_q, empty: (lo_q > hi_q), flag: rdata_q.flag,
                    loop_run: (l_q < r_q), clr_last: (&clr_cnt_q),
                    out_busy: (out_valid_q && out_stall_i)};

  assign out_valid_o    = out_valid_q;
  assign range_result_o = out_res_q;
  assign total_max_o    = out_tot_q;
  assign saturated_o    = out_sat_q;

endmodule

// ----- rtl/ratree_ctrl.sv -----
// ----------------------------------------------------------------------------
// ratree_ctrl
// sequencer: pushdown, range walk, rebuild and result steps of one transaction
// ----------------------------------------------------------------------------
module ratree_ctrl import ratree_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e           state_q, state_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic             path_q, path_d;
  logic             mode_q, mode_d;     // assign pass of the range walk
  logic             clr_op_q, clr_op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      level_q  <= '0;
      path_q   <= 1'b0;
      mode_q   <= 1'b0;
      clr_op_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      level_q  <= level_d;
      path_q   <= path_d;
      mode_q   <= mode_d;
      clr_op_q <= clr_op_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    level_d  = level_q;
    path_d   = path_q;
    mode_d   = mode_q;
    clr_op_d = clr_op_q;
    ctrl_o   = '{load: 1'b0, loop_init: 1'b0, loop_step: 1'b0, sum: 1'b0,
                 out_en: 1'b0, clr_en: 1'b0, rd_sel: RD_NONE, wr_sel: WR_NONE,
                 hold_sel: HOLD_KEEP, level: level_q, path_hi: path_q};
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_CLR: begin
        ctrl_o.clr_en = 1'b1;
        ctrl_o.wr_sel = WR_CLR;
        if (stat_i.clr_last) begin
          state_d  = clr_op_q ? ST_ROOT_RD : ST_IDLE;
          clr_op_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_START;
        end
      end
      ST_START: begin
        level_d = LVL_W'(LEVELS);
        path_d  = 1'b0;
        mode_d  = (stat_i.kind == KIND_ASSIGN);
        if (stat_i.kind == KIND_CLEAR) begin
          clr_op_d = 1'b1;
          state_d  = ST_CLR;
        end else if (stat_i.empty) begin
          state_d = ST_ROOT_RD;
        end else begin
          state_d = ST_PUSH_RD;
        end
      end
      ST_PUSH_RD: begin
        ctrl_o.rd_sel = RD_NODE;
        state_d       = ST_PUSH_CHK;
      end
      ST_PUSH_CHK, ST_PUSH_UT: begin
        if (state_q == ST_PUSH_CHK && stat_i.flag) begin
          ctrl_o.hold_sel = HOLD_TAG;
          state_d         = ST_PUSH_WL;
        end else begin
          if (state_q == ST_PUSH_UT) begin
            ctrl_o.wr_sel = WR_UNTAG;
          end
          if (level_q == LVL_W'(1)) begin
            if (!path_q) begin
              path_d  = 1'b1;
              level_d = LVL_W'(LEVELS);
              state_d = ST_PUSH_RD;
            end else begin
              ctrl_o.loop_init = 1'b1;
              state_d          = ST_LOOP;
            end
          end else begin
            level_d = level_q - 1'b1;
            state_d = ST_PUSH_RD;
          end
        end
      end
      ST_PUSH_WL: begin
        ctrl_o.wr_sel = WR_LEFT_TAG;
        state_d       = ST_PUSH_WR;
      end
      ST_PUSH_WR: begin
        ctrl_o.wr_sel = WR_RIGHT_TAG;
        state_d       = ST_PUSH_UT;
      end
      ST_LOOP: begin
        if (stat_i.loop_run) begin
          ctrl_o.loop_step = 1'b1;
          if (mode_q) begin
            ctrl_o.wr_sel = WR_LOOP;
          end else begin
            ctrl_o.rd_sel = RD_LOOP;
          end
        end else begin
          state_d = ST_LOOP_END;
        end
      end
      ST_LOOP_END: state_d = ST_SUM;
      ST_SUM: begin
        // the result settles after the read pass only
        ctrl_o.sum = !mode_q;
        level_d    = LVL_W'(1);
        path_d     = 1'b0;
        if (mode_q) begin
          state_d = ST_BLD_L;
        end else if (stat_i.kind == KIND_PLACE) begin
          mode_d           = 1'b1;
          ctrl_o.loop_init = 1'b1;
          state_d          = ST_LOOP;
        end else begin
          state_d = ST_ROOT_RD;
        end
      end
      ST_BLD_L: begin
        ctrl_o.rd_sel = RD_LEFT;
        state_d       = ST_BLD_R;
      end
      ST_BLD_R: begin
        ctrl_o.rd_sel   = RD_RIGHT;
        ctrl_o.hold_sel = HOLD_LOAD_MAX;
        state_d         = ST_BLD_N;
      end
      ST_BLD_N: begin
        ctrl_o.rd_sel   = RD_NODE;
        ctrl_o.hold_sel = HOLD_MAX_MAX;
        state_d         = ST_BLD_W;
      end
      ST_BLD_W: begin
        ctrl_o.wr_sel = WR_REBUILD;
        if (level_q == LVL_W'(LEVELS)) begin
          if (!path_q) begin
            path_d  = 1'b1;
            level_d = LVL_W'(1);
            state_d = ST_BLD_L;
          end else begin
            state_d = ST_ROOT_RD;
          end
        end else begin
          level_d = level_q + 1'b1;
          state_d = ST_BLD_L;
        end
      end
      ST_ROOT_RD: begin
        ctrl_o.rd_sel = RD_ROOT;
        state_d       = ST_ROOT_WT;
      end
      ST_ROOT_WT: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_en = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/range_assign_max_tree_top.sv -----
// ----------------------------------------------------------------------------
// range_assign_max_tree_top
// lazy max segment tree over 1024 slots with query, assign, place and clear
// ----------------------------------------------------------------------------
// usage:
//   input channel  in_valid_i / in_stall_o carries kind, range and value
//   output channel out_valid_o / out_stall_i carries one result per transaction
//   a transaction is taken only while the sequencer is idle; one at a time
//   steps: pushdown of both range ends (read, check and, for a tagged node,
//   tag both children and untag it; 10 levels each), the range walk (one
//   step per cycle), a second walk for place, a rebuild of both ends for
//   assign and place (read left, right and node, then write, per level),
//   then the root read, every step through the one node memory read port
//   empty ranges skip straight to the root read
//   clear and reset sweep all 2048 node entries, one per cycle, during
//   which in_stall_o stays high
//   a finished result sits in the output register; a stalled receiver holds
//   it, and the next transaction may already be taken and worked on, but its
//   result waits until the previous one has gone
// ----------------------------------------------------------------------------
module range_assign_max_tree_top import ratree_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    kind_i,
  input  logic [IW-1:0] range_low_i,
  input  logic [IW-1:0] range_high_i,
  input  logic [VW-1:0] value_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [VW-1:0] range_result_o,
  output logic [VW-1:0] total_max_o,
  output logic          saturated_o
);

  ctrl_t ctrl;   // commands from the sequencer
  stat_t stat;   // status back from the datapath

  // sequencer: owns the state, level and end-of-range selection
  ratree_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // datapath: node memory, walk bounds, accumulator, output register
  ratree_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (kind_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .value_i        (value_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .range_result_o (range_result_o),
    .total_max_o    (total_max_o),
    .saturated_o    (saturated_o)
  );

endmodule

// ----- rtl/ratree_checker.sv -----
// ----------------------------------------------------------------------------
// ratree_checker
// port level checks of the range assign max tree
// ----------------------------------------------------------------------------
module ratree_checker import ratree_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input logic [VW-1:0] range_result_o,
  input logic [VW-1:0] total_max_o,
  input logic          saturated_o
);

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // no slot of a range can exceed the whole span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> range_result_o <= total_max_o)
    else $error("range result above total maximum");

  // a clamped place reports the field maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> range_result_o == VMAX)
    else $error("saturated result not clamped");

  // one transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

endmodule

bind range_assign_max_tree_top ratree_checker u_ratree_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .range_result_o (range_result_o),
  .total_max_o    (total_max_o),
  .saturated_o    (saturated_o)
);

// ----- tb/tb_range_assign_max_tree_top.sv -----
// ----------------------------------------------------------------------------
// tb_range_assign_max_tree_top
// self-checking bench: directed and random query/assign/place/clear traffic
// against a flat-array model of the slot heights, random idling on both sides
// ----------------------------------------------------------------------------
module tb_range_assign_max_tree_top;
  import ratree_pkg::*;

  localparam int CYCLE_LIMIT  = 4000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RAND_ITEMS   = 1030;

  typedef struct packed {
    kind_e         kind;
    logic [IW-1:0] lo;
    logic [IW-1:0] hi;
    logic [VW-1:0] val;
  } op_t;

  typedef struct packed {
    logic [VW-1:0] res;
    logic [VW-1:0] total;
    logic          sat;
  } outcome_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    kind = KIND_QUERY;
  logic [IW-1:0] range_low = '0;
  logic [IW-1:0] range_high = '0;
  logic [VW-1:0] value = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [VW-1:0] range_result;
  logic [VW-1:0] total_max;
  logic          saturated;

  // pending items to drive, and outcomes still owed by the block
  op_t      op_queue[$];
  outcome_t outcome_queue[$];

  // flat copy of the slot heights; the tree inside the block must agree
  logic [VW-1:0] slot_height[LEAVES];

  int errors = 0;
  int cycles = 0;
  int sent_count = 0;
  int got_count = 0;
  int kind_count[4];
  int sat_count = 0;
  int empty_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  range_assign_max_tree_top DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .range_low_i    (range_low),
    .range_high_i   (range_high),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .range_result_o (range_result),
    .total_max_o    (total_max),
    .saturated_o    (saturated)
  );

  // apply one operation to the slot model and return what the block must say
  function automatic outcome_t apply_op(op_t op);
    outcome_t         o;
    logic [VW-1:0]    peak;
    logic [VW:0]      sum;
    logic             empty;
    o     = '0;
    peak  = '0;
    empty = (op.lo > op.hi);
    if (op.kind == KIND_CLEAR) begin
      for (int i = 0; i < LEAVES; i++) slot_height[i] = '0;
    end else if (!empty) begin
      for (int i = op.lo; i <= op.hi; i++)
        if (slot_height[i] > peak) peak = slot_height[i];
      case (op.kind)
        KIND_QUERY: o.res = peak;
        KIND_ASSIGN: begin
          o.res = op.val;
          for (int i = op.lo; i <= op.hi; i++) slot_height[i] = op.val;
        end
        default: begin
          // place: stack on top of the tallest slot, clamp at the field max
          sum = {1'b0, peak} + {1'b0, op.val};
          if (sum > {1'b0, VMAX}) begin
            o.res = VMAX;
            o.sat = 1'b1;
          end else begin
            o.res = sum[VW-1:0];
          end
          for (int i = op.lo; i <= op.hi; i++) slot_height[i] = o.res;
        end
      endcase
    end
    for (int i = 0; i < LEAVES; i++)
      if (slot_height[i] > o.total) o.total = slot_height[i];
    return o;
  endfunction

  function automatic op_t make_op(kind_e k, int lo, int hi, logic [VW-1:0] v);
    op_t op;
    op.kind = k;
    op.lo   = lo[IW-1:0];
    op.hi   = hi[IW-1:0];
    op.val  = v;
    return op;
  endfunction

  // append one item to the pending queue
  task automatic queue_op(input op_t op);
    op_queue.insert(op_queue.size(), op);
  endtask

  // random range: mostly short spans, some full, some empty, some wide
  task automatic pick_range(output int lo, output int hi);
    int sel;
    sel = $urandom_range(0, 99);
    lo  = $urandom_range(0, LEAVES - 1);
    if (sel < 65) begin
      hi = lo + $urandom_range(0, 15);
      if (hi > LEAVES - 1) hi = LEAVES - 1;
    end else if (sel < 75) begin
      lo = 0;
      hi = LEAVES - 1;
    end else if (sel < 85) begin
      hi = $urandom_range(0, LEAVES - 1);
      if (hi >= lo) begin
        // force low above high
        lo = (hi == LEAVES - 1) ? hi : hi + 1;
        hi = (lo == 0) ? 0 : lo - 1;
        if (lo == LEAVES - 1 && hi == LEAVES - 1) hi = lo - 1;
      end
    end else begin
      hi = $urandom_range(lo, LEAVES - 1);
    end
  endtask

  function automatic logic [VW-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return VW'($urandom_range(0, 1000));
    if (sel < 65) return VMAX - VW'($urandom_range(0, 2000));
    return VW'($urandom) & VMAX;
  endfunction

  // driver: offers items from op_queue, predicts on each accepted transaction
  always @(posedge clk) begin
    logic taken;
    op_t  cur;
    taken = in_valid && !in_stall;
    if (taken) begin
      cur.kind = kind_e'(kind);
      cur.lo   = range_low;
      cur.hi   = range_high;
      cur.val  = value;
      outcome_queue.insert(outcome_queue.size(), apply_op(cur));
      sent_count++;
      kind_count[kind]++;
      if (cur.kind != KIND_CLEAR && cur.lo > cur.hi) empty_count++;
    end
    if (rst_n && (!in_valid || taken)) begin
      // no idling while items 300..500 go out
      if (op_queue.size() > 0 &&
          ((sent_count >= 300 && sent_count < 500) || $urandom_range(0, 99) >= 28)) begin
        cur = op_queue.pop_front();
        kind       <= cur.kind;
        range_low  <= cur.lo;
        range_high <= cur.hi;
        value      <= cur.val;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each accepted result against the oldest outcome
  always @(posedge clk) begin
    outcome_t want;
    if (out_valid && !out_stall) begin
      got_count++;
      if (outcome_queue.size() == 0) begin
        $display("%0t: result with nothing expected: res=%0d total=%0d sat=%0d",
                 $time, range_result, total_max, saturated);
        errors++;
      end else begin
        want = outcome_queue.pop_front();
        if (want.sat) sat_count++;
        if (range_result !== want.res) begin
          $display("%0t: range_result expected %0d actual %0d", $time, want.res, range_result);
          errors++;
        end
        if (total_max !== want.total) begin
          $display("%0t: total_max expected %0d actual %0d", $time, want.total, total_max);
          errors++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated expected %0d actual %0d", $time, want.sat, saturated);
          errors++;
        end
      end
    end
    // receiver never stalls for results 600..800
    if (got_count >= 600 && got_count < 800) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 28);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, outcome_queue.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int lo, hi, sel;
    kind_e k;
    for (int i = 0; i < LEAVES; i++) slot_height[i] = '0;
    for (int i = 0; i < 4; i++) kind_count[i] = 0;

    // directed: fresh tree, full span, edges, zero assign, overflow, clear
    queue_op(make_op(KIND_QUERY, 0, LEAVES - 1, '0));
    queue_op(make_op(KIND_ASSIGN, 0, LEAVES - 1, VW'(7)));
    queue_op(make_op(KIND_QUERY, 0, 0, '0));
    queue_op(make_op(KIND_ASSIGN, LEAVES - 1, LEAVES - 1, VMAX));
    queue_op(make_op(KIND_QUERY, LEAVES - 2, LEAVES - 1, '0));
    queue_op(make_op(KIND_ASSIGN, 0, 511, '0));           // assign zero
    queue_op(make_op(KIND_QUERY, 0, 511, '0));
    queue_op(make_op(KIND_QUERY, 5, 4, '0));              // empty range
    queue_op(make_op(KIND_ASSIGN, LEAVES - 1, 0, VW'(99))); // empty assign
    queue_op(make_op(KIND_PLACE, 600, 300, VW'(5)));        // empty place
    queue_op(make_op(KIND_PLACE, 500, 520, VW'(10)));
    queue_op(make_op(KIND_PLACE, 510, 530, VW'(3)));
    queue_op(make_op(KIND_PLACE, LEAVES - 2, LEAVES - 1, VW'(1))); // overflow
    queue_op(make_op(KIND_PLACE, 0, LEAVES - 1, VMAX));     // overflow, full span
    queue_op(make_op(KIND_PLACE, 0, 0, '0));
    queue_op(make_op(KIND_CLEAR, LEAVES - 1, 3, VMAX));     // fields ignored
    queue_op(make_op(KIND_QUERY, 0, LEAVES - 1, '0));
    queue_op(make_op(KIND_PLACE, 100, 100, VMAX));
    queue_op(make_op(KIND_PLACE, 100, 100, '0));
    queue_op(make_op(KIND_ASSIGN, 341, 682, VW'(32'h2AAAAAAA)));
    queue_op(make_op(KIND_ASSIGN, 682, 1023, VW'(32'h55555555)));
    queue_op(make_op(KIND_QUERY, 0, LEAVES - 1, '0));
    queue_op(make_op(KIND_CLEAR, 0, 0, '0));

    // random part: mostly stacking and queries on random spans, rare clears
    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 33) k = KIND_QUERY;
      else if (sel < 60) k = KIND_ASSIGN;
      else if (sel < 97) k = KIND_PLACE;
      else k = KIND_CLEAR;
      if (k == KIND_CLEAR) begin
        lo = $urandom_range(0, LEAVES - 1);
        hi = $urandom_range(0, LEAVES - 1);
      end else begin
        pick_range(lo, hi);
      end
      queue_op(make_op(k, lo, hi, pick_value()));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (op_queue.size() == 0 && !in_valid && outcome_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (outcome_queue.size() != 0) begin
      $display("%0d results never arrived", outcome_queue.size());
      errors++;
    end
    $display("ran %0d transactions (query %0d, assign %0d, place %0d, clear %0d)",
             sent_count, kind_count[KIND_QUERY], kind_count[KIND_ASSIGN],
             kind_count[KIND_PLACE], kind_count[KIND_CLEAR]);
    $display("checked %0d results, %0d empty ranges, %0d clamped places, %0d cycles",
             got_count, empty_count, sat_count, cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- range_assign_max_tree_top.f -----
rtl/ratree_pkg.sv
rtl/ratree_dp.sv
rtl/ratree_ctrl.sv
rtl/range_assign_max_tree_top.sv
rtl/ratree_checker.sv
tb/tb_range_assign_max_tree_top.sv
